// ----- hw/rtl/qnun_pkg.sv -----
// Shared constants for the quad Newell unit normal core.
// No dependencies; imported by every module of the core.
package qnun_pkg;

    localparam int NUM_AXES   = 3;
    localparam int NUM_VERTS  = 4;
    // Normal magnitudes are brought below 2^A_BITS before squaring.
    localparam int A_BITS     = 31;
    localparam int SQ_BITS    = 2 * A_BITS;
    localparam int LEN_BITS   = 64;
    // Headroom of the rounding comparator above 2F + LEN_BITS.
    localparam int WIDE_EXTRA = 5;

endpackage

// ----- hw/rtl/qnun_newell.sv -----
// Newell normal front end: edge products, then sums per component.
// Depends on qnun_pkg.
module qnun_newell
    import qnun_pkg::*;
#(
    parameter int CW = 16
) (
    input  logic                       aclk,
    input  logic                       en_prod,
    input  logic                       en_sum,
    input  logic signed [CW-1:0]       vtx [NUM_VERTS][NUM_AXES],
    output logic signed [2*CW+3:0]     n_reg [NUM_AXES]
);

    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;

    logic signed [PW-1:0] prod_reg [NUM_AXES][NUM_VERTS];

    genvar c, k;
    generate
        for (c = 0; c < NUM_AXES; c++) begin : g_axis
            localparam int S = (c + 1) % NUM_AXES;
            localparam int T = (c + 2) % NUM_AXES;
            for (k = 0; k < NUM_VERTS; k++) begin : g_edge
                localparam int J = (k + 1) % NUM_VERTS;
                logic signed [DW-1:0] diff;
                logic signed [DW-1:0] tsum;
                assign diff = {vtx[k][S][CW-1], vtx[k][S]} - {vtx[J][S][CW-1], vtx[J][S]};
                assign tsum = {vtx[k][T][CW-1], vtx[k][T]} + {vtx[J][T][CW-1], vtx[J][T]};
                always_ff @(posedge aclk) begin
                    if (en_prod) begin
                        prod_reg[c][k] <= diff * tsum;
                    end
                end
            end
            always_ff @(posedge aclk) begin
                if (en_sum) begin
                    n_reg[c] <= {{2{prod_reg[c][0][PW-1]}}, prod_reg[c][0]}
                              + {{2{prod_reg[c][1][PW-1]}}, prod_reg[c][1]}
                              + {{2{prod_reg[c][2][PW-1]}}, prod_reg[c][2]}
                              + {{2{prod_reg[c][3][PW-1]}}, prod_reg[c][3]};
                end
            end
        end
    endgenerate

endmodule

// ----- hw/rtl/qnun_prep.sv -----
// Normalization setup: magnitudes and common shift, squares, length and bounds.
// Depends on qnun_pkg.
module qnun_prep
    import qnun_pkg::*;
#(
    parameter int CW = 16,
    parameter int F  = 14
) (
    input  logic                                     aclk,
    input  logic                                     en_mag,
    input  logic                                     en_sq,
    input  logic                                     en_init,
    input  logic signed [2*CW+3:0]                   n_in [NUM_AXES],
    output logic signed [2*F+LEN_BITS+WIDE_EXTRA-1:0] sq_acc_reg [NUM_AXES],
    output logic signed [2*F+LEN_BITS+WIDE_EXTRA-1:0] lin_acc_reg [NUM_AXES],
    output logic signed [2*F+LEN_BITS+WIDE_EXTRA-1:0] bound_reg [NUM_AXES],
    output logic [LEN_BITS-1:0]                      len_reg,
    output logic [NUM_AXES-1:0]                      neg_init_reg
);

    localparam int NW   = 2 * CW + 4;
    localparam int MW   = (NW > A_BITS) ? NW : A_BITS + 1;
    localparam int MAXS = MW - A_BITS;
    localparam int SW   = $clog2(MAXS + 1);
    localparam int WW   = 2 * F + LEN_BITS + WIDE_EXTRA;

    logic [MW-1:0]       mag [NUM_AXES];
    logic [MW-1:0]       mag_or;
    logic [SW-1:0]       sel;
    logic [A_BITS-1:0]   a_reg [NUM_AXES];
    logic [NUM_AXES-1:0] neg_a_reg;
    logic [SQ_BITS-1:0]  sq_reg [NUM_AXES];
    logic [NUM_AXES-1:0] neg_sq_reg;
    logic [LEN_BITS-1:0] len_sum;

    always_comb begin
        mag_or = '0;
        for (int i = 0; i < NUM_AXES; i++) begin
            mag[i] = MW'(n_in[i][NW-1] ? -n_in[i] : n_in[i]);
            mag_or = mag_or | mag[i];
        end
        // Smallest shift that brings the largest magnitude below 2^A_BITS.
        sel = SW'(MAXS);
        for (int s = MAXS; s >= 0; s--) begin
            if ((mag_or >> s) < (MW'(1) << A_BITS)) begin
                sel = SW'(s);
            end
        end
    end

    assign len_sum = LEN_BITS'(sq_reg[0]) + LEN_BITS'(sq_reg[1]) + LEN_BITS'(sq_reg[2]);

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_AXES; i++) begin
            if (en_mag) begin
                a_reg[i]     <= A_BITS'(mag[i] >> sel);
                neg_a_reg[i] <= n_in[i][NW-1];
            end
            if (en_sq) begin
                sq_reg[i]     <= a_reg[i] * a_reg[i];
                neg_sq_reg[i] <= neg_a_reg[i];
            end
            if (en_init) begin
                // Start from quotient zero, where the odd factor is minus one.
                sq_acc_reg[i]   <= $signed(WW'(len_sum));
                lin_acc_reg[i]  <= -$signed(WW'(len_sum));
                bound_reg[i]    <= $signed(WW'(sq_reg[i]) << (2 * F + 2));
                neg_init_reg[i] <= neg_sq_reg[i];
            end
        end
        if (en_init) begin
            len_reg <= len_sum;
        end
    end

endmodule

// ----- hw/rtl/qnun_step.sv -----
// One bit of the rounded quotient a * 2^F / sqrt(L) for one component.
// Depends on qnun_pkg.
module qnun_step
    import qnun_pkg::*;
#(
    parameter int F   = 14,
    parameter int BIT = 0
) (
    input  logic                                     aclk,
    input  logic                                     en,
    input  logic signed [2*F+LEN_BITS+WIDE_EXTRA-1:0] sq_acc_in,
    input  logic signed [2*F+LEN_BITS+WIDE_EXTRA-1:0] lin_acc_in,
    input  logic signed [2*F+LEN_BITS+WIDE_EXTRA-1:0] bound_in,
    input  logic [LEN_BITS-1:0]                      len_in,
    input  logic [F:0]                               quo_in,
    input  logic                                     neg_in,
    output logic signed [2*F+LEN_BITS+WIDE_EXTRA-1:0] sq_acc_reg,
    output logic signed [2*F+LEN_BITS+WIDE_EXTRA-1:0] lin_acc_reg,
    output logic signed [2*F+LEN_BITS+WIDE_EXTRA-1:0] bound_reg,
    output logic [LEN_BITS-1:0]                      len_reg,
    output logic [F:0]                               quo_reg,
    output logic                                     neg_reg
);

    localparam int WW = 2 * F + LEN_BITS + WIDE_EXTRA;

    logic signed [WW-1:0] len_w;
    logic signed [WW-1:0] trial;
    logic                 fits;
    logic [F:0]           quo_next;

    // With r = 2q - 1 held as r^2 L and r L, raising q by 2^BIT adds
    // 2^(BIT+2) r L + 2^(2 BIT + 2) L to r^2 L.
    assign len_w = $signed(WW'(len_in));
    assign trial = sq_acc_in + (lin_acc_in <<< (BIT + 2)) + (len_w <<< (2 * BIT + 2));
    assign fits  = (trial <= bound_in);

    always_comb begin
        quo_next      = quo_in;
        quo_next[BIT] = fits;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_acc_reg  <= fits ? trial : sq_acc_in;
            lin_acc_reg <= fits ? lin_acc_in + (len_w <<< (BIT + 1)) : lin_acc_in;
            bound_reg   <= bound_in;
            len_reg     <= len_in;
            quo_reg     <= quo_next;
            neg_reg     <= neg_in;
        end
    end

endmodule

// ----- hw/rtl/quad_newell_unit_normal_core.sv -----
// Quad Newell unit normal core: handshake, pipeline control and output stage.
// Depends on qnun_pkg, qnun_newell, qnun_prep and qnun_step.
//
// Accepts one quadrilateral (four Q8.8 vertices) per clock while s_tready is
// high and returns its unit normal in signed Q2.14, one result per quad in
// order. Two stages form the Newell sums, three set up magnitudes, squares and
// length, one stage per quotient bit resolves the rounded reciprocal square
// root scaling, and one stage applies the sign. Every stage holds its item
// while the next one is full and cannot move on, so a stalled output fills the
// pipeline bubbles before the input stalls.
module quad_newell_unit_normal_core
    import qnun_pkg::*;
#(
    parameter int COORD_WIDTH      = 16,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // v0_x, v0_y, v0_z, v1_x, ..., v3_z from the lowest bit up
    input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // norm_x, norm_y, norm_z from the lowest bit up
    output logic [((3*(NORMAL_FRAC_BITS+2)+7)/8)*8-1:0] m_tdata
);

    localparam int CW  = COORD_WIDTH;
    localparam int F   = NORMAL_FRAC_BITS;
    localparam int OW  = F + 2;
    localparam int MTW = ((3 * OW + 7) / 8) * 8;
    localparam int WW  = 2 * F + LEN_BITS + WIDE_EXTRA;
    localparam int FIRST_STEP = 5;
    localparam int NS  = F + 7;
    localparam int ONE = 1 << F;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS:0]   rdy;

    logic signed [CW-1:0]     vtx [NUM_VERTS][NUM_AXES];
    logic signed [2*CW+3:0]   newell_n [NUM_AXES];
    logic signed [WW-1:0]     sq_init    [NUM_AXES];
    logic signed [WW-1:0]     lin_init   [NUM_AXES];
    logic signed [WW-1:0]     bound_init [NUM_AXES];
    logic signed [WW-1:0]     sq_ch    [NUM_AXES][F+2];
    logic signed [WW-1:0]     lin_ch   [NUM_AXES][F+2];
    logic signed [WW-1:0]     bound_ch [NUM_AXES][F+2];
    logic [LEN_BITS-1:0]      len_ch   [NUM_AXES][F+2];
    logic [F:0]               quo_ch   [NUM_AXES][F+2];
    logic                     neg_ch   [NUM_AXES][F+2];
    logic [LEN_BITS-1:0]      len_init;
    logic [NUM_AXES-1:0]      neg_init;
    logic signed [OW-1:0]     norm_reg [NUM_AXES];

    // An item moves into a stage whenever that stage is empty or moves on.
    always_comb begin
        rdy[NS] = m_tready;
        for (int i = NS - 1; i >= 0; i--) begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
    end

    assign s_tready   = rdy[0];
    assign m_tvalid   = valid_reg[NS-1];
    assign valid_next = {valid_reg[NS-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= (valid_next & rdy[NS-1:0]) | (valid_reg & ~rdy[NS-1:0]);
        end
    end

    genvar k, c, b;
    generate
        for (k = 0; k < NUM_VERTS; k++) begin : g_vert
            for (c = 0; c < NUM_AXES; c++) begin : g_coord
                assign vtx[k][c] = s_tdata[(k*NUM_AXES+c)*CW +: CW];
            end
        end
    endgenerate

    qnun_newell #(
        .CW (CW)
    ) u_newell (
        .aclk    (aclk),
        .en_prod (rdy[0]),
        .en_sum  (rdy[1]),
        .vtx     (vtx),
        .n_reg   (newell_n)
    );

    qnun_prep #(
        .CW (CW),
        .F  (F)
    ) u_prep (
        .aclk         (aclk),
        .en_mag       (rdy[2]),
        .en_sq        (rdy[3]),
        .en_init      (rdy[4]),
        .n_in         (newell_n),
        .sq_acc_reg   (sq_init),
        .lin_acc_reg  (lin_init),
        .bound_reg    (bound_init),
        .len_reg      (len_init),
        .neg_init_reg (neg_init)
    );

    generate
        for (c = 0; c < NUM_AXES; c++) begin : g_lane
            assign sq_ch[c][0]    = sq_init[c];
            assign lin_ch[c][0]   = lin_init[c];
            assign bound_ch[c][0] = bound_init[c];
            assign len_ch[c][0]   = len_init;
            assign quo_ch[c][0]   = '0;
            assign neg_ch[c][0]   = neg_init[c];
            for (b = 0; b <= F; b++) begin : g_bit
                qnun_step #(
                    .F   (F),
                    .BIT (F - b)
                ) u_step (
                    .aclk        (aclk),
                    .en          (rdy[FIRST_STEP+b]),
                    .sq_acc_in   (sq_ch[c][b]),
                    .lin_acc_in  (lin_ch[c][b]),
                    .bound_in    (bound_ch[c][b]),
                    .len_in      (len_ch[c][b]),
                    .quo_in      (quo_ch[c][b]),
                    .neg_in      (neg_ch[c][b]),
                    .sq_acc_reg  (sq_ch[c][b+1]),
                    .lin_acc_reg (lin_ch[c][b+1]),
                    .bound_reg   (bound_ch[c][b+1]),
                    .len_reg     (len_ch[c][b+1]),
                    .quo_reg     (quo_ch[c][b+1]),
                    .neg_reg     (neg_ch[c][b+1])
                );
            end
            // A zero-length normal comes out as zero.
            always_ff @(posedge aclk) begin
                if (rdy[NS-1]) begin
                    if (len_ch[c][F+1] == '0) begin
                        norm_reg[c] <= '0;
                    end else if (neg_ch[c][F+1]) begin
                        norm_reg[c] <= -$signed(OW'(quo_ch[c][F+1]));
                    end else begin
                        norm_reg[c] <= $signed(OW'(quo_ch[c][F+1]));
                    end
                end
            end
        end
    endgenerate

    assign m_tdata = MTW'({norm_reg[2], norm_reg[1], norm_reg[0]});

    a_mag_x: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (norm_reg[0] <= ONE && norm_reg[0] >= -ONE))
        else $error("norm_x exceeds unit magnitude");
    a_mag_z: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (norm_reg[2] <= ONE && norm_reg[2] >= -ONE))
        else $error("norm_z exceeds unit magnitude");
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg[NS-1] |-> s_tready)
        else $error("input stalled with an empty output stage");
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for quad_newell_unit_normal_core: streams quads in, predicts each
// unit normal independently, and compares every result transfer field by field.
// Depends on qnun_pkg and the core RTL only.
module tb;
    import qnun_pkg::*;

    localparam int CW   = 16;
    localparam int FB   = 14;
    localparam int IN_W = ((12*CW+7)/8)*8;
    localparam int OUT_W = ((3*(FB+2)+7)/8)*8;
    localparam int N_RANDOM = 1930;

    class normal_scoreboard;
        logic [OUT_W-1:0] pending_normals[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        // Rounded a * 2^FB / sqrt(len): largest q in [0, 2^FB] with
        // (2q-1)^2 * len <= 4 * a^2 * 2^(2*FB).
        function logic [15:0] scaled_mag(logic [63:0] a, logic [63:0] len);
            logic [127:0] rhs;
            logic [127:0] lhs;
            logic [63:0] lo, hi, mid, odd;
            rhs = ({64'd0, a} * {64'd0, a}) << (2*FB + 2);
            lo = 0;
            hi = 64'd1 << FB;
            while (lo < hi) begin
                mid = lo + (hi - lo + 1) / 2;
                odd = 2*mid - 1;
                lhs = {64'd0, odd*odd} * {64'd0, len};
                if (lhs <= rhs) lo = mid;
                else hi = mid - 1;
            end
            return lo[15:0];
        endfunction

        function logic [OUT_W-1:0] unit_normal(logic [IN_W-1:0] quad);
            longint c[4][3];
            longint n[3];
            logic [63:0] m[3];
            logic [63:0] top, len;
            logic [15:0] q;
            logic [OUT_W-1:0] r;
            int j;
            for (int k = 0; k < 4; k++)
                for (int i = 0; i < 3; i++)
                    c[k][i] = longint'($signed(quad[(k*3+i)*CW +: CW]));
            n = '{0, 0, 0};
            for (int k = 0; k < 4; k++) begin
                j = (k + 1) % 4;
                n[0] += (c[k][1] - c[j][1]) * (c[j][2] + c[k][2]);
                n[1] += (c[k][2] - c[j][2]) * (c[j][0] + c[k][0]);
                n[2] += (c[k][0] - c[j][0]) * (c[j][1] + c[k][1]);
            end
            top = 0;
            for (int i = 0; i < 3; i++) begin
                m[i] = n[i] < 0 ? 64'(-n[i]) : 64'(n[i]);
                if (m[i] > top) top = m[i];
            end
            // Large normals are brought below 2^31 by a common truncating shift.
            while (top >= 64'd1 << 31) begin
                top = top >> 1;
                for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            end
            len = m[0]*m[0] + m[1]*m[1] + m[2]*m[2];
            r = '0;
            for (int i = 0; i < 3; i++) begin
                q = (len == 0) ? 16'd0 : scaled_mag(m[i], len);
                r[i*16 +: 16] = n[i] < 0 ? -q : q;
            end
            return r;
        endfunction

        function void note_quad(logic [IN_W-1:0] quad);
            pending_normals.push_back(unit_normal(quad));
        endfunction

        function void check_normal(logic [OUT_W-1:0] got);
            logic [OUT_W-1:0] want;
            string names[3];
            names = '{"norm_x", "norm_y", "norm_z"};
            if (pending_normals.size() == 0) begin
                $error("result transfer with no quad outstanding: %h", got);
                errors++;
                return;
            end
            want = pending_normals.pop_front();
            for (int i = 0; i < 3; i++)
                if (want[i*16 +: 16] !== got[i*16 +: 16]) begin
                    $error("%s expected %0d actual %0d", names[i],
                           $signed(want[i*16 +: 16]), $signed(got[i*16 +: 16]));
                    errors++;
                end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [IN_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_W-1:0] m_tdata;

    normal_scoreboard sb;
    bit hold_request;
    bit stimulus_done;
    int sent;

    quad_newell_unit_normal_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic bit idle_now();
        // No idling at all for a stretch in the middle of the random part.
        if (sent >= 300 && sent < 550) return 0;
        return $urandom_range(99) < 29;
    endfunction

    task automatic send_quad(logic [IN_W-1:0] quad);
        while (idle_now()) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= quad;
        do @(posedge aclk); while (!s_tready);
        sb.note_quad(quad);
        sent++;
    endtask

    function automatic logic [IN_W-1:0] make_quad(logic [15:0] v[12]);
        logic [IN_W-1:0] q;
        q = '0;
        for (int i = 0; i < 12; i++) q[i*CW +: CW] = v[i];
        return q;
    endfunction

    function automatic logic [IN_W-1:0] random_quad();
        logic [15:0] v[12];
        logic [15:0] base;
        int kind, span;
        kind = $urandom_range(3);
        span = 1 << $urandom_range(15);
        base = 16'($urandom);
        for (int i = 0; i < 12; i++) begin
            case (kind)
                0: v[i] = 16'($urandom);
                1: v[i] = 16'($urandom_range(2*span) - span);
                // Planar quad with one shared coordinate.
                2: v[i] = (i % 3 == 2) ? base : 16'($urandom_range(2*span) - span);
                default: v[i] = $urandom_range(1) ? 16'h8000 + 16'($urandom_range(3))
                                                  : 16'h7fff - 16'($urandom_range(3));
            endcase
        end
        return make_quad(v);
    endfunction

    initial begin
        logic [15:0] v[12];
        sb = new();
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        m_tready = 0;
        hold_request = 0;
        stimulus_done = 0;
        sent = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Zero-length normal, extremes of every coordinate, unit squares on each plane,
        // degenerate quads and a maximal-magnitude normal that needs the shift.
        v = '{default: 16'h0000};            send_quad(make_quad(v));
        v = '{default: 16'h7fff};            send_quad(make_quad(v));
        v = '{default: 16'h8000};            send_quad(make_quad(v));
        v = '{0,0,0, 256,0,0, 256,256,0, 0,256,0};      send_quad(make_quad(v));
        v = '{0,0,0, 0,256,0, 256,256,0, 256,0,0};      send_quad(make_quad(v));
        v = '{0,0,0, 0,256,0, 0,256,256, 0,0,256};      send_quad(make_quad(v));
        v = '{0,0,0, 0,0,256, 256,0,256, 256,0,0};      send_quad(make_quad(v));
        v = '{0,0,0, 1,0,0, 1,1,0, 0,1,0};              send_quad(make_quad(v));
        v = '{16'h8000,16'h8000,0, 16'h7fff,16'h8000,0,
              16'h7fff,16'h7fff,0, 16'h8000,16'h7fff,0}; send_quad(make_quad(v));
        v = '{16'h8000,16'h8000,16'h8000, 16'h7fff,16'h8000,16'h7fff,
              16'h7fff,16'h7fff,16'h8000, 16'h8000,16'h7fff,16'h7fff};
        send_quad(make_quad(v));
        v = '{5,5,5, 5,5,5, 5,5,5, 9,9,9};              send_quad(make_quad(v));
        v = '{0,0,0, 10,20,30, 20,40,60, 30,60,90};     send_quad(make_quad(v));
        v = '{0,0,0, 256,0,0, 256,256,256, 0,256,256};  send_quad(make_quad(v));
        v = '{16'hffff,16'hffff,16'hffff, 1,16'hffff,0, 1,1,1, 16'hffff,1,0};
        send_quad(make_quad(v));
        v = '{100,16'hff00,3, 16'h8000,77,16'h7fff, 12,16'h7fff,16'h8000, 0,1,2};
        send_quad(make_quad(v));

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 700) hold_request <= 1;
            if (n == 1300) begin
                s_tvalid <= 0;
                while (sb.pending_normals.size() != 0) @(posedge aclk);
            end
            send_quad(random_quad());
        end
        s_tvalid <= 0;
        stimulus_done = 1;
    end

    initial begin
        int hold;
        hold = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) sb.check_normal(m_tdata);
            if (hold_request && hold == 0) begin
                hold_request <= 0;
                hold = 400;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 0;
            end else if (sent >= 300 && sent < 550) begin
                m_tready <= 1;
            end else begin
                m_tready <= $urandom_range(99) >= 29;
            end
        end
    end

    initial begin
        wait (stimulus_done);
        while (sb.pending_normals.size() != 0) @(posedge aclk);
        repeat (FB + 20) @(posedge aclk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ----- filelist.f -----
hw/rtl/qnun_pkg.sv
hw/rtl/qnun_newell.sv
hw/rtl/qnun_prep.sv
hw/rtl/qnun_step.sv
hw/rtl/quad_newell_unit_normal_core.sv
test/tb.sv
